FILE: sv/scptrg_pkg.sv
// package for the scope trigger detector: widths, codes and reset values
`timescale 1ns / 1ps
`default_nettype none

package scptrg_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int MODE_W     = 3;
    localparam int LEVEL_W    = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;

    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t CFG_TRIGGER_MODE = 2'd0;
    localparam cfg_idx_t CFG_THRESHOLD    = 2'd1;
    localparam cfg_idx_t CFG_HYSTERESIS   = 2'd2;

    localparam mode_t MODE_NONE    = 3'd0;
    localparam mode_t MODE_RISING  = 3'd1;
    localparam mode_t MODE_FALLING = 3'd2;
    localparam mode_t MODE_LEVEL   = 3'd3;
    localparam mode_t MODE_MANUAL  = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_MANUAL = 1'b1;

    localparam level_t THRESHOLD_RESET  = 15'd3277;
    localparam level_t HYSTERESIS_RESET = 15'd0;

endpackage

`default_nettype wire

FILE: sv/scptrg_if.sv
// stream interfaces for sample transactions and block result transactions
`timescale 1ns / 1ps
`default_nettype none

interface scptrg_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_block;

    modport source (output valid, output operation, output sample, output last_in_block,
                    input ready);
    modport sink   (input valid, input operation, input sample, input last_in_block,
                    output ready);
endinterface

interface scptrg_result_if;
    logic valid;
    logic ready;
    logic block_triggered;

    modport source (output valid, output block_triggered, input ready);
    modport sink   (input valid, input block_triggered, output ready);
endinterface

`default_nettype wire

FILE: sv/scope_trigger_detector_top.sv
// scope trigger detector: edge, level and manual trigger over sample blocks
//
//   channel    | direction | payload                               | handshake
//   sample_ch  | in        | operation, sample, last_in_block      | valid/ready
//   result_ch  | out       | block_triggered                       | valid/ready
//   cfg        | in        | cfg_index, cfg_data                   | cfg_we
//
// one transaction per cycle sustained while results are taken; the input register, then the result register
// the loop on the trigger state closes at the compute register
// a stalled result holds the compute stage; an empty input register still takes one more
// reset clears registers to mode none, threshold 3277, hysteresis 0
`timescale 1ns / 1ps
`default_nettype none

module scope_trigger_detector_top
    import scptrg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire cfg_idx_t         cfg_index,
    input  wire cfg_data_t        cfg_data,
    scptrg_sample_if.sink         sample_ch,
    scptrg_result_if.source       result_ch
);

    localparam int CMP_W = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 3;

    mode_t  trigger_mode_reg;
    level_t threshold_reg;
    level_t hysteresis_reg;

    logic                          s1_valid_reg;
    logic                          s1_op_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                          s1_last_reg;

    logic signed [SAMPLE_BITS-1:0] previous_sample_reg, previous_sample_next;
    logic                          level_latched_reg, level_latched_next;
    logic                          manual_pending_reg, manual_pending_next;
    logic                          block_fired_reg, block_fired_next;

    logic out_valid_reg;
    logic out_flag_reg, out_flag_next;
    logic produce;

    logic s1_fire;
    logic in_fire;

    logic signed [CMP_W-1:0] s_ext, prev_ext, thr_ext, hys_ext, lo_bound, hi_bound, mag;
    logic hit, above, examine;

    assign s1_fire = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire = sample_ch.valid && sample_ch.ready;

    assign result_ch.valid = out_valid_reg;
    assign result_ch.block_triggered = out_flag_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_mode_reg <= MODE_NONE;
            threshold_reg    <= THRESHOLD_RESET;
            hysteresis_reg   <= HYSTERESIS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_MODE: trigger_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_HYSTERESIS:   hysteresis_reg   <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            s1_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= sample_ch.operation;
            s1_sample_reg <= sample_ch.sample;
            s1_last_reg   <= sample_ch.last_in_block;
        end
    end

    // trigger evaluation
    always_comb
    begin
        s_ext    = {{(CMP_W-SAMPLE_BITS){s1_sample_reg[SAMPLE_BITS-1]}}, s1_sample_reg};
        prev_ext = {{(CMP_W-SAMPLE_BITS){previous_sample_reg[SAMPLE_BITS-1]}},
                    previous_sample_reg};
        thr_ext  = {{(CMP_W-LEVEL_W){1'b0}}, threshold_reg};
        hys_ext  = {{(CMP_W-LEVEL_W){1'b0}}, hysteresis_reg};
        lo_bound = thr_ext - hys_ext;
        hi_bound = thr_ext + hys_ext;
        mag      = s_ext[CMP_W-1] ? -s_ext : s_ext;
        above    = mag > thr_ext;

        previous_sample_next = previous_sample_reg;
        level_latched_next   = level_latched_reg;
        manual_pending_next  = manual_pending_reg;
        block_fired_next     = block_fired_reg;
        out_flag_next        = 1'b0;
        produce              = 1'b0;
        hit                  = 1'b0;
        examine              = 1'b0;

        if (s1_op_reg == OP_MANUAL)
        begin
            manual_pending_next = 1'b1;
        end
        else
        begin
            examine = (trigger_mode_reg != MODE_NONE) && (trigger_mode_reg != MODE_MANUAL)
                      && !block_fired_reg;
            if (examine)
            begin
                previous_sample_next = s1_sample_reg;
                if (trigger_mode_reg == MODE_RISING)
                begin
                    hit = (prev_ext < lo_bound) && (s_ext >= thr_ext);
                end
                else if (trigger_mode_reg == MODE_FALLING)
                begin
                    hit = (prev_ext > hi_bound) && (s_ext <= thr_ext);
                end
                else if (trigger_mode_reg == MODE_LEVEL)
                begin
                    if (!level_latched_reg && above)
                    begin
                        level_latched_next = 1'b1;
                        hit                = 1'b1;
                    end
                    else if (!above && (mag < lo_bound))
                    begin
                        level_latched_next = 1'b0;
                    end
                end
            end

            if (s1_last_reg)
            begin
                produce          = 1'b1;
                block_fired_next = 1'b0;
                if (trigger_mode_reg == MODE_NONE)
                begin
                    out_flag_next = 1'b1;
                end
                else if (trigger_mode_reg == MODE_MANUAL)
                begin
                    out_flag_next       = manual_pending_reg;
                    manual_pending_next = 1'b0;
                end
                else
                begin
                    out_flag_next = block_fired_reg || hit;
                end
            end
            else
            begin
                block_fired_next = block_fired_reg || hit;
            end
        end
    end

    // trigger state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_sample_reg <= '0;
            level_latched_reg   <= 1'b0;
            manual_pending_reg  <= 1'b0;
            block_fired_reg     <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else if (s1_fire)
        begin
            previous_sample_reg <= previous_sample_next;
            level_latched_reg   <= level_latched_next;
            manual_pending_reg  <= manual_pending_next;
            block_fired_reg     <= block_fired_next;
            out_valid_reg       <= produce;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && produce)
        begin
            out_flag_reg <= out_flag_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/scptrg_checker.sv
// port-level checks for the scope trigger detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module scptrg_checker
    import scptrg_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cfg_we,
    input wire cfg_idx_t  cfg_index,
    input wire cfg_data_t cfg_data,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      in_operation,
    input wire logic      in_last,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire logic      out_flag
);

    logic       mode_none_reg;
    logic [2:0] pending_reg;
    logic       block_end_in;
    logic       result_out;

    assign block_end_in = in_valid && in_ready && (in_operation == OP_SAMPLE) && in_last;
    assign result_out   = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_none_reg <= 1'b1;
            pending_reg   <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_TRIGGER_MODE))
            begin
                mode_none_reg <= (cfg_data[MODE_W-1:0] == MODE_NONE);
            end
            pending_reg <= pending_reg + {2'b0, block_end_in} - {2'b0, result_out};
        end
    end

    // stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_flag))
        else $error("result changed while stalled");

    // every result answers an accepted block end
    a_result_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a block end");

    // input side never blocked while the result side is empty
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // in mode none every block reports a trigger
    a_none_mode_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_none_reg |-> out_flag)
        else $error("mode none gave a clear block flag");

endmodule

bind scope_trigger_detector_top scptrg_checker u_scptrg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .in_operation (sample_ch.operation),
    .in_last      (sample_ch.last_in_block),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .out_flag     (result_ch.block_triggered)
);

`default_nettype wire

FILE: tb/sv/tb_scope_trigger_detector_top.sv
// self-checking testbench for the scope trigger detector with directed and random blocks
`timescale 1ns / 1ps

module tb_scope_trigger_detector_top;
    import scptrg_pkg::*;

    localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
    localparam int TOTAL_ITEMS  = 900;
    localparam int QUIET_FROM   = 780;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 38;

    localparam mode_t MODE_SPARE = 3'd7;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} row_kind_e;
    typedef enum logic [1:0] {CHK_PRED, CHK_ONE, CHK_ZERO} check_e;

    typedef struct packed {
        row_kind_e              kind;
        logic                   op;
        logic [SAMPLE_BITS-1:0] smp;
        logic                   last;
        cfg_idx_t               idx;
        cfg_data_t              data;
        check_e                 chk;
    } step_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    scptrg_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    scptrg_result_if result_ch ();

    scope_trigger_detector_top #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_ch(sample_ch),
        .result_ch(result_ch)
    );

    // trigger state tracked alongside the block
    mode_t   trig_mode;
    level_t  trig_thr;
    level_t  trig_hys;
    sample_t prev_smp;
    bit      level_disarmed;
    bit      manual_req;
    bit      fired_in_block;

    bit flag_q[$];
    int errors;
    int items_sent;
    int cycles;
    bit quiet;
    int tx_odds;
    int rx_odds;
    int rx_stall_left;

    function automatic step_t cfg_row(input cfg_idx_t idx, input cfg_data_t data);
        step_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        r.chk = CHK_PRED;
        return r;
    endfunction

    function automatic step_t item_row(input logic op, input int smp, input logic last,
                                       input check_e chk);
        step_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = op;
        r.smp = smp[SAMPLE_BITS-1:0];
        r.last = last;
        r.chk = chk;
        return r;
    endfunction

    step_t dir_steps [DIR_ROWS] = '{
        item_row(OP_SAMPLE, 32767, 1'b1, CHK_ONE),
        item_row(OP_SAMPLE, -32768, 1'b1, CHK_ONE),
        cfg_row(CFG_TRIGGER_MODE, cfg_data_t'(MODE_RISING)),
        cfg_row(CFG_THRESHOLD, 15'd16384),
        item_row(OP_SAMPLE, -32768, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, 16384, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, -32768, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, 16384, 1'b1, CHK_ONE),
        item_row(OP_SAMPLE, 20000, 1'b1, CHK_ZERO),
        cfg_row(CFG_THRESHOLD, 15'd32767),
        cfg_row(CFG_HYSTERESIS, 15'd32767),
        item_row(OP_SAMPLE, -1, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, 32767, 1'b1, CHK_ONE),
        cfg_row(CFG_TRIGGER_MODE, cfg_data_t'(MODE_FALLING)),
        cfg_row(CFG_THRESHOLD, 15'd0),
        item_row(OP_SAMPLE, 32767, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, -32768, 1'b1, CHK_ZERO),
        cfg_row(CFG_HYSTERESIS, 15'd0),
        item_row(OP_SAMPLE, 1, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, 0, 1'b1, CHK_ONE),
        cfg_row(CFG_TRIGGER_MODE, cfg_data_t'(MODE_LEVEL)),
        cfg_row(CFG_THRESHOLD, 15'd32767),
        item_row(OP_SAMPLE, 32767, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, -32768, 1'b1, CHK_ONE),
        item_row(OP_SAMPLE, 0, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, -32768, 1'b1, CHK_ONE),
        item_row(OP_MANUAL, 21845, 1'b1, CHK_PRED),
        cfg_row(CFG_TRIGGER_MODE, cfg_data_t'(MODE_MANUAL)),
        item_row(OP_SAMPLE, 0, 1'b1, CHK_ONE),
        item_row(OP_SAMPLE, 0, 1'b1, CHK_ZERO),
        cfg_row(CFG_TRIGGER_MODE, cfg_data_t'(MODE_RISING)),
        cfg_row(CFG_THRESHOLD, 15'd16384),
        item_row(OP_SAMPLE, -32768, 1'b0, CHK_PRED),
        item_row(OP_SAMPLE, 32767, 1'b0, CHK_PRED),
        cfg_row(CFG_TRIGGER_MODE, cfg_data_t'(MODE_SPARE)),
        item_row(OP_SAMPLE, 0, 1'b1, CHK_ONE),
        item_row(OP_SAMPLE, 0, 1'b1, CHK_ZERO),
        cfg_row(CFG_TRIGGER_MODE, cfg_data_t'(MODE_NONE))
    };

    // returns 1 when the transaction closes a block, with the block flag
    function automatic bit predict_block_flag(input logic op, input sample_t smp,
                                              input logic last, output bit flag);
        longint s;
        longint thr;
        longint hys;
        longint prev;
        longint mag;
        bit     hit;
        s = smp;
        thr = trig_thr;
        hys = trig_hys;
        prev = prev_smp;
        hit = 1'b0;
        flag = 1'b0;
        if (op == OP_MANUAL)
        begin
            manual_req = 1'b1;
            return 1'b0;
        end
        if (trig_mode != MODE_NONE && trig_mode != MODE_MANUAL && !fired_in_block)
        begin
            if (trig_mode == MODE_RISING)
            begin
                hit = (prev < thr - hys) && (s >= thr);
            end
            else if (trig_mode == MODE_FALLING)
            begin
                hit = (prev > thr + hys) && (s <= thr);
            end
            else if (trig_mode == MODE_LEVEL)
            begin
                mag = (s < 0) ? -s : s;
                if (!level_disarmed && mag > thr)
                begin
                    level_disarmed = 1'b1;
                    hit = 1'b1;
                end
                else if (!(mag > thr) && mag < thr - hys)
                begin
                    level_disarmed = 1'b0;
                end
            end
            prev_smp = smp;
            if (hit)
                fired_in_block = 1'b1;
        end
        if (!last)
            return 1'b0;
        if (trig_mode == MODE_NONE)
        begin
            flag = 1'b1;
        end
        else if (trig_mode == MODE_MANUAL)
        begin
            flag = manual_req;
            manual_req = 1'b0;
        end
        else
        begin
            flag = fired_in_block;
        end
        fired_in_block = 1'b0;
        return 1'b1;
    endfunction

    function automatic sample_t pick_sample();
        longint v;
        longint thr;
        longint hys;
        longint off;
        thr = trig_thr;
        hys = trig_hys;
        off = longint'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 7))
            0, 1: v = longint'($urandom_range(0, 65535)) - 32768;
            2: v = thr + off;
            3: v = -thr + off;
            4: v = thr - hys + off;
            5: v = thr + hys + off;
            6: v = -(thr - hys) + off;
            default: v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic wait_results_done();
        sample_ch.valid <= 1'b0;
        while (flag_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input cfg_idx_t idx, input cfg_data_t data);
        wait_results_done();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TRIGGER_MODE: trig_mode = data[MODE_W-1:0];
            CFG_THRESHOLD:    trig_thr = data;
            CFG_HYSTERESIS:   trig_hys = data;
            default: ;
        endcase
    endtask

    task automatic send_item(input logic op, input sample_t smp, input logic last,
                             input check_e chk);
        bit flag;
        sample_ch.valid <= 1'b1;
        sample_ch.operation <= op;
        sample_ch.sample <= smp;
        sample_ch.last_in_block <= last;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        if (predict_block_flag(op, smp, last, flag))
        begin
            if (chk == CHK_ONE)
                flag_q.push_back(1'b1);
            else if (chk == CHK_ZERO)
                flag_q.push_back(1'b0);
            else
                flag_q.push_back(flag);
        end
        items_sent++;
        quiet = (items_sent >= QUIET_FROM);
        if (!quiet && tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_scope_trigger_detector_top failed");
            $finish;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (flag_q.size() == 0)
            begin
                $error("block_triggered: no transaction expected, actual %0b",
                       result_ch.block_triggered);
                errors++;
            end
            else if (result_ch.block_triggered !== flag_q[0])
            begin
                $error("block_triggered: expected %0b, actual %0b",
                       flag_q[0], result_ch.block_triggered);
                errors++;
                void'(flag_q.pop_front());
            end
            else
            begin
                void'(flag_q.pop_front());
            end
        end
        if (rx_stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            rx_stall_left--;
        end
        else if (!quiet && rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0)
        begin
            result_ch.ready <= 1'b0;
            rx_stall_left = $urandom_range(1, 12) - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int      phase;
        int      n;
        int      pos;
        int      blk_len;
        logic    last;
        mode_t   mode;
        level_t  thr;
        level_t  hys;
        step_t   row;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TRIGGER_MODE;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.operation = OP_SAMPLE;
        sample_ch.sample = '0;
        sample_ch.last_in_block = 1'b0;
        result_ch.ready = 1'b0;
        trig_mode = MODE_NONE;
        trig_thr = THRESHOLD_RESET;
        trig_hys = HYSTERESIS_RESET;
        prev_smp = '0;
        level_disarmed = 1'b0;
        manual_req = 1'b0;
        fired_in_block = 1'b0;
        tx_odds = 4;
        rx_odds = 4;
        rx_stall_left = 0;
        quiet = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            row = dir_steps[i];
            if (row.kind == ROW_CFG)
                set_reg(row.idx, row.data);
            else
                send_item(row.op, sample_t'(row.smp), row.last, row.chk);
        end

        phase = 0;
        pos = 0;
        blk_len = 4;
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                mode = mode_t'($urandom_range(0, 7));
            else
                mode = mode_t'($urandom_range(1, 4));
            case ($urandom_range(0, 7))
                0: thr = '0;
                1: thr = '1;
                default: thr = level_t'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 7))
                0, 1: hys = '0;
                2: hys = '1;
                3: hys = level_t'($urandom_range(0, 32767));
                default: hys = level_t'($urandom_range(0, 4096));
            endcase
            set_reg(CFG_TRIGGER_MODE, cfg_data_t'(mode));
            set_reg(CFG_THRESHOLD, thr);
            set_reg(CFG_HYSTERESIS, hys);
            tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            n = $urandom_range(30, 90);
            for (int k = 0; k < n; k++)
            begin
                // in phase 2, halfway through, the sender holds off until the result stream runs dry
                if (phase == 2 && k == n / 2)
                    wait_results_done();
                if ($urandom_range(0, 15) == 0)
                begin
                    send_item(OP_MANUAL, sample_t'($urandom_range(0, 65535)),
                              logic'($urandom_range(0, 1)), CHK_PRED);
                end
                else
                begin
                    last = (pos >= blk_len - 1);
                    send_item(OP_SAMPLE, pick_sample(), last, CHK_PRED);
                    pos++;
                    if (last)
                    begin
                        pos = 0;
                        if ($urandom_range(0, 9) == 0)
                            blk_len = $urandom_range(9, 40);
                        else
                            blk_len = $urandom_range(1, 8);
                    end
                end
            end
            phase++;
        end

        wait_results_done();
        if (errors == 0)
            $display("tb_scope_trigger_detector_top passed");
        else
            $display("tb_scope_trigger_detector_top failed");
        $finish;
    end

endmodule
